// File: rtl/jss_pkg.sv
package jss_pkg;

    // Default widths of the position counter and the nesting depth
    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int DEPTH_BITS_DEFAULT    = 16;

    // Width of the reported position fields
    localparam int REPORT_BITS = 16;

    // Characters that steer the scan
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;

    // Result kinds carried on tuser
    localparam logic [1:0] KIND_BALANCED = 2'd0;
    localparam logic [1:0] KIND_TAIL     = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;

endpackage

// File: rtl/json_span_scanner_core.sv
// Bracket-balanced span finder for a byte stream of JSON-like text.
//
// Input channel s_axis: one text byte per beat in tdata, tlast marks the
// final byte of a text. Output channel m_axis: one result beat per span
// that closes, plus one at the final byte of a text where none closes.
// tdata carries the start and end positions of the span, tuser the kind
// (balanced, tail, none), and tlast is set for a result from the final byte.
//
// Throughput is one byte per cycle while no result waits on a full output:
// each byte passes an input register and the span state (flags, depth
// counter, position counter) is updated from that register, the result
// going to an output register, from which m_axis shows it.
//
// Reset clears the span state, the position counter and both valid flags.
// When the receiver stalls with a result held, bytes that produce no
// result keep flowing; a byte that produces a result waits in the input
// register and s_axis_tready drops until the output register frees up.
// After the final byte of a text the span state and position counter clear.
module json_span_scanner_core #(
    parameter int POSITION_BITS = jss_pkg::POSITION_BITS_DEFAULT,
    parameter int DEPTH_BITS    = jss_pkg::DEPTH_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] span_start, [31:16] span_end
    output logic [1:0]  m_axis_tuser,   // [1:0] span_kind
    output logic        m_axis_tlast    // text_done
);

    localparam int RB = jss_pkg::REPORT_BITS;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // Input register
    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;

    // Span state
    logic                     inside_reg,  inside_next;
    logic                     square_reg,  square_next;
    logic [DEPTH_BITS-1:0]    depth_reg,   depth_next;
    logic                     quotes_reg,  quotes_next;
    logic                     escape_reg,  escape_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic [POSITION_BITS-1:0] open_reg,    open_next;

    // Output register
    logic                     out_valid_reg;
    logic [RB-1:0]            out_start_reg;
    logic [RB-1:0]            out_end_reg;
    logic [1:0]               out_kind_reg;
    logic                     out_done_reg;

    logic                     closed;
    logic                     has_result;
    logic                     out_free;
    logic                     advance;
    logic [7:0]               opener;
    logic [7:0]               closer;
    logic [DEPTH_BITS-1:0]    depth_dec;
    logic [POSITION_BITS+RB-1:0] start_wide;
    logic [POSITION_BITS+RB-1:0] end_wide;
    logic [RB-1:0]            res_start;
    logic [RB-1:0]            res_end;
    logic [1:0]               res_kind;

    // Pick the bracket pair of the open span
    assign opener    = square_reg ? jss_pkg::CHAR_LBRACKET : jss_pkg::CHAR_LBRACE;
    assign closer    = square_reg ? jss_pkg::CHAR_RBRACKET : jss_pkg::CHAR_RBRACE;
    assign depth_dec = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;

    // Scan one byte against the span state
    always_comb
    begin
        inside_next = inside_reg;
        square_next = square_reg;
        depth_next  = depth_reg;
        quotes_next = quotes_reg;
        escape_next = escape_reg;
        open_next   = open_reg;
        closed      = 1'b0;

        if (!inside_reg)
        begin
            if (in_byte_reg == jss_pkg::CHAR_LBRACE || in_byte_reg == jss_pkg::CHAR_LBRACKET)
            begin
                inside_next = 1'b1;
                square_next = (in_byte_reg == jss_pkg::CHAR_LBRACKET);
                depth_next  = DEPTH_BITS'(1);
                quotes_next = 1'b0;
                escape_next = 1'b0;
                open_next   = pos_reg;
            end
        end
        else if (quotes_reg)
        begin
            if (escape_reg)
            begin
                escape_next = 1'b0;
            end
            else if (in_byte_reg == jss_pkg::CHAR_BACKSLASH)
            begin
                escape_next = 1'b1;
            end
            else if (in_byte_reg == jss_pkg::CHAR_QUOTE)
            begin
                quotes_next = 1'b0;
            end
        end
        else if (in_byte_reg == jss_pkg::CHAR_QUOTE)
        begin
            quotes_next = 1'b1;
        end
        else if (in_byte_reg == opener)
        begin
            if (depth_reg != DEPTH_MAX)
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
        else if (in_byte_reg == closer)
        begin
            depth_next = depth_dec;
            if (depth_dec == '0)
            begin
                closed      = 1'b1;
                inside_next = 1'b0;
                quotes_next = 1'b0;
                escape_next = 1'b0;
            end
        end

        // Advance the position, or clear everything after the final byte
        pos_next = pos_reg + 1'b1;
        if (in_last_reg)
        begin
            inside_next = 1'b0;
            square_next = 1'b0;
            depth_next  = '0;
            quotes_next = 1'b0;
            escape_next = 1'b0;
            pos_next    = '0;
            open_next   = '0;
        end
    end

    // Form the result of this byte; a span opened on this byte starts here
    assign start_wide = {{RB{1'b0}}, (inside_reg ? open_reg : pos_reg)};
    assign end_wide   = {{RB{1'b0}}, pos_reg};
    assign has_result = closed || in_last_reg;

    always_comb
    begin
        res_start = start_wide[RB-1:0];
        res_end   = end_wide[RB-1:0];
        res_kind  = jss_pkg::KIND_BALANCED;
        if (!closed)
        begin
            if (inside_reg || (in_byte_reg == jss_pkg::CHAR_LBRACE)
                || (in_byte_reg == jss_pkg::CHAR_LBRACKET))
            begin
                res_kind = jss_pkg::KIND_TAIL;
            end
            else
            begin
                res_kind  = jss_pkg::KIND_NONE;
                res_start = '0;
                res_end   = '0;
            end
        end
    end

    // Handshake: a byte moves on unless its result finds the output full
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Update the span state once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            square_reg <= 1'b0;
            depth_reg  <= '0;
            quotes_reg <= 1'b0;
            escape_reg <= 1'b0;
            pos_reg    <= '0;
            open_reg   <= '0;
        end
        else if (advance)
        begin
            inside_reg <= inside_next;
            square_reg <= square_next;
            depth_reg  <= depth_next;
            quotes_reg <= quotes_next;
            escape_reg <= escape_next;
            pos_reg    <= pos_next;
            open_reg   <= open_next;
        end
    end

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_start_reg <= res_start;
            out_end_reg   <= res_end;
            out_kind_reg  <= res_kind;
            out_done_reg  <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_end_reg, out_start_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_done_reg;

    // A span is open exactly while the depth is nonzero
    a_depth_tracks_span: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg == (depth_reg != '0))
        else $error("depth and span flag disagree");

    // Tail and empty outcomes only come from the final byte
    a_end_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != jss_pkg::KIND_BALANCED) |-> m_axis_tlast)
        else $error("end-of-text outcome without text_done");

    // An empty outcome reports zero positions
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == jss_pkg::KIND_NONE) |-> (m_axis_tdata == '0))
        else $error("no-span result carries positions");

    // The final byte clears the position counter and the span
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> (pos_reg == '0) && !inside_reg && !quotes_reg)
        else $error("state not cleared after final byte");

endmodule

// File: tb/tb_json_span_scanner_core.sv
`timescale 1ns / 100ps

module tb_json_span_scanner_core;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int CALM_ITEMS     = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PRESSURE_SPANS = 10;

    localparam int PB = jss_pkg::POSITION_BITS_DEFAULT;
    localparam int DB = jss_pkg::DEPTH_BITS_DEFAULT;

    // Span finder predictor and queue of spans still to be reported
    class span_scoreboard;
        typedef struct packed {
            logic [jss_pkg::REPORT_BITS-1:0] first_pos;
            logic [jss_pkg::REPORT_BITS-1:0] last_pos;
            logic [1:0]                      kind;
            logic                            done;
        } span_report_t;

        bit                in_span;
        bit                square;
        bit                in_quotes;
        bit                escaped;
        logic [DB-1:0]     depth;
        logic [PB-1:0]     pos;
        logic [PB-1:0]     open_pos;
        span_report_t      pending_spans[$];
        int                fail_count;

        function new();
            fail_count = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            in_span   = 1'b0;
            square    = 1'b0;
            in_quotes = 1'b0;
            escaped   = 1'b0;
            depth     = '0;
            pos       = '0;
            open_pos  = '0;
        endfunction

        function int pending();
            return pending_spans.size();
        endfunction

        function void queue_report(span_report_t rep);
            pending_spans.insert(pending_spans.size(), rep);
        endfunction

        // Advance the scan by one accepted byte and queue any span it reports
        function void note_byte(logic [7:0] b, bit last);
            logic [7:0]   opener;
            logic [7:0]   closer;
            bit           closed;
            span_report_t rep;
            closed = 1'b0;
            opener = square ? jss_pkg::CHAR_LBRACKET : jss_pkg::CHAR_LBRACE;
            closer = square ? jss_pkg::CHAR_RBRACKET : jss_pkg::CHAR_RBRACE;
            if (!in_span)
            begin
                if (b == jss_pkg::CHAR_LBRACE || b == jss_pkg::CHAR_LBRACKET)
                begin
                    in_span   = 1'b1;
                    square    = (b == jss_pkg::CHAR_LBRACKET);
                    depth     = DB'(1);
                    in_quotes = 1'b0;
                    escaped   = 1'b0;
                    open_pos  = pos;
                end
            end
            else if (in_quotes)
            begin
                if (escaped)
                    escaped = 1'b0;
                else if (b == jss_pkg::CHAR_BACKSLASH)
                    escaped = 1'b1;
                else if (b == jss_pkg::CHAR_QUOTE)
                    in_quotes = 1'b0;
            end
            else if (b == jss_pkg::CHAR_QUOTE)
            begin
                in_quotes = 1'b1;
            end
            else if (b == opener)
            begin
                // hold the depth at its top value
                if (depth != '1)
                    depth = depth + 1'b1;
            end
            else if (b == closer)
            begin
                if (depth != '0)
                    depth = depth - 1'b1;
                if (depth == '0)
                begin
                    closed    = 1'b1;
                    in_span   = 1'b0;
                    in_quotes = 1'b0;
                    escaped   = 1'b0;
                end
            end

            if (closed)
            begin
                rep = '{first_pos: open_pos[jss_pkg::REPORT_BITS-1:0],
                        last_pos: pos[jss_pkg::REPORT_BITS-1:0],
                        kind: jss_pkg::KIND_BALANCED, done: last};
                queue_report(rep);
            end
            else if (last && in_span)
            begin
                rep = '{first_pos: open_pos[jss_pkg::REPORT_BITS-1:0],
                        last_pos: pos[jss_pkg::REPORT_BITS-1:0],
                        kind: jss_pkg::KIND_TAIL, done: 1'b1};
                queue_report(rep);
            end
            else if (last)
            begin
                rep = '{first_pos: '0, last_pos: '0, kind: jss_pkg::KIND_NONE, done: 1'b1};
                queue_report(rep);
            end

            if (last)
                clear_scan();
            else
                pos = pos + 1'b1;
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            fail_count++;
            $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $time);
        endtask

        // Compare one result beat with the oldest queued span
        task check_result(logic [jss_pkg::REPORT_BITS-1:0] s,
                          logic [jss_pkg::REPORT_BITS-1:0] e,
                          logic [1:0] k, logic d);
            span_report_t want;
            if (pending_spans.size() == 0)
            begin
                report_mismatch("unexpected result, span_start", 32'(s), 32'hFFFF_FFFF);
                return;
            end
            want = pending_spans.pop_front();
            if (s !== want.first_pos)
                report_mismatch("span_start", 32'(s), 32'(want.first_pos));
            if (e !== want.last_pos)
                report_mismatch("span_end", 32'(e), 32'(want.last_pos));
            if (k !== want.kind)
                report_mismatch("span_kind", 32'(k), 32'(want.kind));
            if (d !== want.done)
                report_mismatch("text_done", 32'(d), 32'(want.done));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    span_scoreboard sb = new();

    logic [7:0] text_q[$];
    bit         tx_idle_en = 1'b0;
    bit         rx_idle_en = 1'b0;
    bit         hold_request = 1'b0;
    int         stall_left = 0;
    int         quiet_cycles = 0;

    json_span_scanner_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Track accepted bytes and check result beats on the same edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser,
                            m_axis_tlast);
    end

    // Abort when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Drive tready: long hold on request, random stall bursts otherwise
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Special characters half the time, any byte otherwise
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 11))
            0: return jss_pkg::CHAR_LBRACE;
            1: return jss_pkg::CHAR_LBRACKET;
            2: return jss_pkg::CHAR_RBRACE;
            3: return jss_pkg::CHAR_RBRACKET;
            4: return jss_pkg::CHAR_BACKSLASH;
            5: return jss_pkg::CHAR_QUOTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Any byte that neither starts nor ends a string
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == jss_pkg::CHAR_QUOTE || b == jss_pkg::CHAR_BACKSLASH)
            b = 8'h61;
        return b;
    endfunction

    // Append one byte to the text being built
    task automatic add_byte(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic push_string(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // Build one text: mostly bracket spans with strings, sometimes plain noise
    task automatic build_text();
        int         d;
        int         budget;
        bit         sq;
        logic [7:0] op;
        logic [7:0] cl;
        text_q.delete();
        if ($urandom_range(0, 9) < 2)
        begin
            repeat ($urandom_range(1, 20))
                add_byte(pick_char());
            return;
        end
        repeat ($urandom_range(1, 3))
        begin
            repeat ($urandom_range(0, 3))
                add_byte(pick_plain());
            sq = 1'($urandom_range(0, 1));
            op = sq ? jss_pkg::CHAR_LBRACKET : jss_pkg::CHAR_LBRACE;
            cl = sq ? jss_pkg::CHAR_RBRACKET : jss_pkg::CHAR_RBRACE;
            add_byte(op);
            d = 1;
            budget = $urandom_range(1, 20);
            while (d > 0 && budget > 0)
            begin
                budget--;
                case ($urandom_range(0, 7))
                    0, 1:
                    begin
                        if (d < 6)
                        begin
                            add_byte(op);
                            d++;
                        end
                    end
                    2, 3:
                    begin
                        add_byte(cl);
                        d--;
                    end
                    4:
                    begin
                        // quoted string with escapes and stray brackets
                        add_byte(jss_pkg::CHAR_QUOTE);
                        repeat ($urandom_range(0, 5))
                        begin
                            if ($urandom_range(0, 2) == 0)
                            begin
                                add_byte(jss_pkg::CHAR_BACKSLASH);
                                add_byte(pick_char());
                            end
                            else if ($urandom_range(0, 1) == 0)
                                add_byte(sq ? jss_pkg::CHAR_RBRACKET : jss_pkg::CHAR_RBRACE);
                            else
                                add_byte(pick_plain());
                        end
                        add_byte(jss_pkg::CHAR_QUOTE);
                    end
                    5:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            add_byte(sq ? jss_pkg::CHAR_LBRACE : jss_pkg::CHAR_LBRACKET);
                        else
                            add_byte(sq ? jss_pkg::CHAR_RBRACE : jss_pkg::CHAR_RBRACKET);
                    end
                    default:
                        add_byte(pick_plain());
                endcase
            end
            // close most spans, leave some open as a tail
            if (d > 0 && $urandom_range(0, 3) != 0)
                repeat (d) add_byte(cl);
        end
        repeat ($urandom_range(0, 2))
            add_byte(pick_plain());
    endtask

    // Offer one byte, wait for it to be taken, then maybe idle
    task automatic send_byte(logic [7:0] b, bit last);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (tx_idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // Stop offering and wait until every queued span has been reported
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // single zero byte: no span at end of text
        text_q.delete();
        add_byte(8'h00);
        send_text();
        // opener on the final byte: tail
        text_q.delete();
        push_string("{");
        send_text();
        // square span, curly ignored, escaped quote and bracket inside a string
        text_q.delete();
        push_string("[{\"]\\\"\"]");
        send_text();
        // span closing mid-text, stray closer, then no span at the end
        text_q.delete();
        add_byte(8'hFF);
        push_string("{}}");
        add_byte(8'hFF);
        send_text();
        // nested tail
        text_q.delete();
        push_string("{{}x");
        send_text();
        wait_drained();

        // receiver holds off while many spans close back to back
        tx_idle_en = 1'b0;
        hold_request = 1'b1;
        text_q.delete();
        repeat (PRESSURE_SPANS) push_string("{}");
        push_string("z");
        send_text();
        wait_drained();

        // random texts, calm toward the end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            build_text();
            send_text();
            sent += text_q.size();
            if (tx_idle_en && $urandom_range(0, 19) == 0)
                wait_drained();
        end
        wait_drained();

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
